// File: design/fuwm_pkg.sv
package fuwm_pkg;

   localparam int OP_W      = 2;
   localparam int FRAME_W   = 32;
   localparam int SIZE_W    = 24;
   localparam int USAGE_W   = 32;
   localparam int CNT_OUT_W = 7;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 32;

   localparam logic [OP_W-1:0] OP_BEGIN_FRAME   = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOCATE      = 2'd1;
   localparam logic [OP_W-1:0] OP_READ_STATS    = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR_HISTORY = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_WARNING_LEVEL  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRITICAL_LEVEL = 1'd1;

   typedef struct packed {
      logic begin_frame;
      logic allocate;
      logic clear;
      logic stats_start;
      logic rd_issue;
      logic div_load;
      logic div_step;
      logic load_out;
   } fuwm_cmd_type;

   typedef struct packed {
      logic window_empty;
      logic last_read;
      logic div_last;
      logic out_free;
   } fuwm_sts_type;

endpackage

// File: design/fuwm_req_if.sv
interface fuwm_req_if;
   logic                         valid;
   logic                         ready;
   logic [fuwm_pkg::OP_W-1:0]    operation;
   logic [fuwm_pkg::FRAME_W-1:0] frame_number;
   logic [fuwm_pkg::SIZE_W-1:0]  size_bytes;

   modport source (output valid, output operation, output frame_number, output size_bytes,
                   input ready);
   modport sink (input valid, input operation, input frame_number, input size_bytes,
                 output ready);
endinterface

// File: design/fuwm_rsp_if.sv
interface fuwm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [fuwm_pkg::USAGE_W-1:0]   average_usage;
   logic [fuwm_pkg::USAGE_W-1:0]   peak_usage;
   logic [fuwm_pkg::USAGE_W-1:0]   minimum_usage;
   logic [fuwm_pkg::CNT_OUT_W-1:0] frames_counted;
   logic [fuwm_pkg::CNT_OUT_W-1:0] warning_frames;
   logic [fuwm_pkg::CNT_OUT_W-1:0] critical_frames;

   modport source (output valid, output average_usage, output peak_usage,
                   output minimum_usage, output frames_counted, output warning_frames,
                   output critical_frames, input ready);
   modport sink (input valid, input average_usage, input peak_usage,
                 input minimum_usage, input frames_counted, input warning_frames,
                 input critical_frames, output ready);
endinterface

// File: design/fuwm_ram.sv
module fuwm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/fuwm_ctrl.sv
module fuwm_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fuwm_pkg::OP_W-1:0]     req_operation,
   input  fuwm_pkg::fuwm_sts_type        sts,
   output fuwm_pkg::fuwm_cmd_type        cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_TAIL   = 3'd2;
   localparam logic [2:0] ST_LOAD   = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_operation)
                  fuwm_pkg::OP_BEGIN_FRAME:   cmd.begin_frame = 1'b1;
                  fuwm_pkg::OP_ALLOCATE:      cmd.allocate    = 1'b1;
                  fuwm_pkg::OP_CLEAR_HISTORY: cmd.clear       = 1'b1;
                  fuwm_pkg::OP_READ_STATS: begin
                     cmd.stats_start = 1'b1;
                     state_in        = sts.window_empty ? ST_FINISH : ST_SCAN;
                  end
                  default: cmd = '0;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.rd_issue = 1'b1;
            if (sts.last_read) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/fuwm_dp.sv
module fuwm_dp #(
   parameter int WINDOW_FRAMES = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  fuwm_pkg::fuwm_cmd_type             cmd,
   output fuwm_pkg::fuwm_sts_type             sts,
   input  logic [fuwm_pkg::FRAME_W-1:0]       req_frame_number,
   input  logic [fuwm_pkg::SIZE_W-1:0]        req_size_bytes,
   input  logic                               csr_write_enable,
   input  logic [fuwm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fuwm_pkg::CSR_W-1:0]         csr_write_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [fuwm_pkg::USAGE_W-1:0]       rsp_average_usage,
   output logic [fuwm_pkg::USAGE_W-1:0]       rsp_peak_usage,
   output logic [fuwm_pkg::USAGE_W-1:0]       rsp_minimum_usage,
   output logic [fuwm_pkg::CNT_OUT_W-1:0]     rsp_frames_counted,
   output logic [fuwm_pkg::CNT_OUT_W-1:0]     rsp_warning_frames,
   output logic [fuwm_pkg::CNT_OUT_W-1:0]     rsp_critical_frames
);

   localparam int UW        = fuwm_pkg::USAGE_W;
   localparam int OW        = fuwm_pkg::CNT_OUT_W;
   localparam int IDX_W     = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
   localparam int CNT_W     = $clog2(WINDOW_FRAMES + 1);
   localparam int SUM_W     = UW + CNT_W;
   localparam int DIV_CNT_W = $clog2(SUM_W);
   localparam logic [CNT_W-1:0]     WIN_MAX  = CNT_W'(WINDOW_FRAMES);
   localparam logic [IDX_W-1:0]     IDX_LAST = IDX_W'(WINDOW_FRAMES - 1);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

   // configuration
   logic [UW-1:0] warn_lvl_ff, crit_lvl_ff;

   // running frame and window bookkeeping
   logic [fuwm_pkg::FRAME_W-1:0] frame_id_ff, frame_id_in;
   logic [UW-1:0]                total_ff, total_in;
   logic [UW-1:0]                peak_ff, peak_in;
   logic [IDX_W-1:0]             head_ff, head_in;
   logic [CNT_W-1:0]             count_ff, count_in;

   // window walk
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             empty_ff, empty_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [UW-1:0]    pk_ff, pk_in;
   logic [UW-1:0]    mn_ff, mn_in;
   logic [CNT_W-1:0] warn_cnt_ff, warn_cnt_in;
   logic [CNT_W-1:0] crit_cnt_ff, crit_cnt_in;

   // bit-serial divider
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [CNT_W:0]       rem_sh;
   logic                 rem_ge;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [UW-1:0] avg_out_ff, pk_out_ff, mn_out_ff;
   logic [OW-1:0] frames_out_ff, warn_out_ff, crit_out_ff;

   logic                 push;
   logic [2*UW-1:0]      ram_rd_data;
   logic [UW-1:0]        t_rd, p_rd;
   logic [UW:0]          alloc_sum;
   logic [CNT_W+OW-1:0]  count_ext, warn_ext, crit_ext;

   assign push = cmd.begin_frame && (frame_id_ff != '0);

   fuwm_ram #(
      .WIDTH (2 * UW),
      .DEPTH (WINDOW_FRAMES)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (head_ff),
      .wr_data ({total_ff, peak_ff}),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign t_rd = ram_rd_data[2*UW-1:UW];
   assign p_rd = ram_rd_data[UW-1:0];

   assign sts.window_empty = (count_ff == '0);
   assign sts.last_read    = (CNT_W'(rd_idx_ff) == (count_ff - CNT_W'(1)));
   assign sts.div_last     = (div_cnt_ff == DIV_LAST);
   assign sts.out_free     = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         warn_lvl_ff <= '0;
         crit_lvl_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            fuwm_pkg::CSR_WARNING_LEVEL:  warn_lvl_ff <= csr_write_data;
            fuwm_pkg::CSR_CRITICAL_LEVEL: crit_lvl_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // running frame
   assign alloc_sum = {1'b0, total_ff} + (UW + 1)'(req_size_bytes);

   always_comb begin
      frame_id_in = frame_id_ff;
      total_in    = total_ff;
      peak_in     = peak_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      if (cmd.begin_frame) begin
         frame_id_in = req_frame_number;
         total_in    = '0;
         peak_in     = '0;
         if (push) begin
            head_in = (head_ff == IDX_LAST) ? '0 : head_ff + IDX_W'(1);
            if (count_ff != WIN_MAX) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
      end
      if (cmd.allocate) begin
         total_in = alloc_sum[UW] ? '1 : alloc_sum[UW-1:0];
         if (total_in > peak_ff) begin
            peak_in = total_in;
         end
      end
      if (cmd.clear) begin
         head_in  = '0;
         count_in = '0;
      end
   end

   // window walk and accumulation
   always_comb begin
      rd_idx_in   = rd_idx_ff;
      rd_vld_in   = cmd.rd_issue;
      empty_in    = empty_ff;
      sum_in      = sum_ff;
      pk_in       = pk_ff;
      mn_in       = mn_ff;
      warn_cnt_in = warn_cnt_ff;
      crit_cnt_in = crit_cnt_ff;
      if (cmd.stats_start) begin
         rd_idx_in   = '0;
         empty_in    = (count_ff == '0);
         sum_in      = '0;
         pk_in       = '0;
         mn_in       = '1;
         warn_cnt_in = '0;
         crit_cnt_in = '0;
      end else begin
         if (cmd.rd_issue) begin
            rd_idx_in = rd_idx_ff + IDX_W'(1);
         end
         if (rd_vld_ff) begin
            sum_in = sum_ff + SUM_W'(t_rd);
            if (p_rd > pk_ff) begin
               pk_in = p_rd;
            end
            if (t_rd < mn_ff) begin
               mn_in = t_rd;
            end
            if (t_rd > crit_lvl_ff) begin
               crit_cnt_in = crit_cnt_ff + CNT_W'(1);
            end else if (t_rd > warn_lvl_ff) begin
               warn_cnt_in = warn_cnt_ff + CNT_W'(1);
            end
         end
      end
   end

   // restoring division of the window sum by the frame count, one bit per cycle
   assign rem_sh = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_ge = (rem_sh >= {1'b0, count_ff});

   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.div_load) begin
         quo_in     = sum_ff;
         rem_in     = '0;
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         quo_in     = {quo_ff[SUM_W-2:0], rem_ge};
         rem_in     = rem_ge ? CNT_W'(rem_sh - {1'b0, count_ff}) : rem_sh[CNT_W-1:0];
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   assign count_ext = (CNT_W + OW)'(count_ff);
   assign warn_ext  = (CNT_W + OW)'(warn_cnt_ff);
   assign crit_ext  = (CNT_W + OW)'(crit_cnt_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_id_ff  <= '0;
         total_ff     <= '0;
         peak_ff      <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         frame_id_ff  <= frame_id_in;
         total_ff     <= total_in;
         peak_ff      <= peak_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      empty_ff    <= empty_in;
      sum_ff      <= sum_in;
      pk_ff       <= pk_in;
      mn_ff       <= mn_in;
      warn_cnt_ff <= warn_cnt_in;
      crit_cnt_ff <= crit_cnt_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      div_cnt_ff  <= div_cnt_in;
      if (cmd.load_out) begin
         if (empty_ff) begin
            avg_out_ff    <= total_ff;
            pk_out_ff     <= peak_ff;
            mn_out_ff     <= total_ff;
            frames_out_ff <= OW'(1);
            warn_out_ff   <= {{(OW - 1){1'b0}}, (total_ff > warn_lvl_ff)};
            crit_out_ff   <= {{(OW - 1){1'b0}}, (total_ff > crit_lvl_ff)};
         end else begin
            avg_out_ff    <= quo_ff[UW-1:0];
            pk_out_ff     <= pk_ff;
            mn_out_ff     <= mn_ff;
            frames_out_ff <= count_ext[OW-1:0];
            warn_out_ff   <= warn_ext[OW-1:0];
            crit_out_ff   <= crit_ext[OW-1:0];
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_average_usage   = avg_out_ff;
   assign rsp_peak_usage      = pk_out_ff;
   assign rsp_minimum_usage   = mn_out_ff;
   assign rsp_frames_counted  = frames_out_ff;
   assign rsp_warning_frames  = warn_out_ff;
   assign rsp_critical_frames = crit_out_ff;

endmodule

// File: design/frame_usage_window_monitor.sv
// Frame usage monitor: tracks the saturating byte total and peak of the running frame and keeps
// the totals and peaks of the last WINDOW_FRAMES frames in a ring held in RAM. begin_frame,
// allocate and clear_history leave the block ready, and the next word is taken in the cycle after.
// read_stats walks the ring one entry per cycle through the RAM read port and then divides the
// window sum by a bit-serial restoring divider, one quotient bit per cycle; it occupies the block
// until the result is loaded, and with an empty window it skips the walk and the division. The
// result sits in an output register, so further frame and allocate words are taken while it
// waits to be read. The ring needs no clearing after reset.
module frame_usage_window_monitor #(
   parameter int WINDOW_FRAMES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   fuwm_req_if.sink                          req_chan,
   fuwm_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [fuwm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fuwm_pkg::CSR_W-1:0]        csr_write_data
);

   fuwm_pkg::fuwm_cmd_type cmd;
   fuwm_pkg::fuwm_sts_type sts;

   fuwm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_operation (req_chan.operation),
      .sts           (sts),
      .cmd           (cmd)
   );

   fuwm_dp #(
      .WINDOW_FRAMES (WINDOW_FRAMES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_frame_number    (req_chan.frame_number),
      .req_size_bytes      (req_chan.size_bytes),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_chan.valid),
      .rsp_ready           (rsp_chan.ready),
      .rsp_average_usage   (rsp_chan.average_usage),
      .rsp_peak_usage      (rsp_chan.peak_usage),
      .rsp_minimum_usage   (rsp_chan.minimum_usage),
      .rsp_frames_counted  (rsp_chan.frames_counted),
      .rsp_warning_frames  (rsp_chan.warning_frames),
      .rsp_critical_frames (rsp_chan.critical_frames)
   );

   a_stats_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.operation == fuwm_pkg::OP_READ_STATS)
         |=> !req_chan.ready)
      else $error("block ready right after a stats request");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_chan.valid)
      else $error("loaded result not presented");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.begin_frame, cmd.allocate, cmd.clear, cmd.stats_start, cmd.rd_issue,
                cmd.div_load, cmd.div_step, cmd.load_out}))
      else $error("more than one datapath command at once");

endmodule

// File: dv/frame_usage_window_monitor_tb.sv
`timescale 1ns / 1ps

module frame_usage_window_monitor_tb;

   localparam int WINDOW_FRAMES = 64;

   typedef struct packed {
      logic [fuwm_pkg::OP_W-1:0]    operation;
      logic [fuwm_pkg::FRAME_W-1:0] frame_number;
      logic [fuwm_pkg::SIZE_W-1:0]  size_bytes;
   } usage_word_type;

   typedef struct packed {
      logic [fuwm_pkg::USAGE_W-1:0]   average_usage;
      logic [fuwm_pkg::USAGE_W-1:0]   peak_usage;
      logic [fuwm_pkg::USAGE_W-1:0]   minimum_usage;
      logic [fuwm_pkg::CNT_OUT_W-1:0] frames_counted;
      logic [fuwm_pkg::CNT_OUT_W-1:0] warning_frames;
      logic [fuwm_pkg::CNT_OUT_W-1:0] critical_frames;
   } usage_stats_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_write_enable;
   logic [fuwm_pkg::CSR_IDX_W-1:0] csr_index;
   logic [fuwm_pkg::CSR_W-1:0]     csr_write_data;

   fuwm_req_if req_if ();
   fuwm_rsp_if rsp_if ();

   frame_usage_window_monitor #(
      .WINDOW_FRAMES(WINDOW_FRAMES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   usage_word_type  pending_words[$];
   usage_stats_type stats_expected[$];
   usage_word_type  word_on_bus;
   int              mismatches = 0;
   bit              steady = 1'b0;

   // shadow of the block state
   logic [31:0] warn_level;
   logic [31:0] crit_level;
   logic [31:0] frame_id = '0;
   logic [31:0] frame_total = '0;
   logic [31:0] frame_peak = '0;
   logic [31:0] ring_totals[WINDOW_FRAMES];
   logic [31:0] ring_peaks[WINDOW_FRAMES];
   int          ring_head = 0;
   int          ring_count = 0;

   task automatic apply_usage_word(usage_word_type w);
      logic [32:0]     grown;
      logic [63:0]     sum;
      logic [31:0]     pk;
      logic [31:0]     mn;
      int              nw;
      int              nc;
      usage_stats_type s;
      case (w.operation)
         fuwm_pkg::OP_BEGIN_FRAME: begin
            if (frame_id != 0) begin
               ring_totals[ring_head] = frame_total;
               ring_peaks[ring_head] = frame_peak;
               ring_head = (ring_head + 1) % WINDOW_FRAMES;
               if (ring_count < WINDOW_FRAMES) ring_count++;
            end
            frame_total = '0;
            frame_peak = '0;
            frame_id = w.frame_number;
         end
         fuwm_pkg::OP_ALLOCATE: begin
            grown = {1'b0, frame_total} + {9'd0, w.size_bytes};
            frame_total = grown[32] ? 32'hFFFF_FFFF : grown[31:0];
            if (frame_total > frame_peak) frame_peak = frame_total;
         end
         fuwm_pkg::OP_READ_STATS: begin
            if (ring_count == 0) begin
               s.average_usage = frame_total;
               s.peak_usage = frame_peak;
               s.minimum_usage = frame_total;
               s.frames_counted = 7'd1;
               s.warning_frames = (frame_total > warn_level) ? 7'd1 : 7'd0;
               s.critical_frames = (frame_total > crit_level) ? 7'd1 : 7'd0;
            end else begin
               sum = '0;
               pk = '0;
               mn = 32'hFFFF_FFFF;
               nw = 0;
               nc = 0;
               for (int i = 0; i < ring_count; i++) begin
                  sum += {32'd0, ring_totals[i]};
                  if (ring_peaks[i] > pk) pk = ring_peaks[i];
                  if (ring_totals[i] < mn) mn = ring_totals[i];
                  if (ring_totals[i] > crit_level) nc++;
                  else if (ring_totals[i] > warn_level) nw++;
               end
               sum = sum / 64'(ring_count);
               s.average_usage = sum[31:0];
               s.peak_usage = pk;
               s.minimum_usage = mn;
               s.frames_counted = fuwm_pkg::CNT_OUT_W'(ring_count);
               s.warning_frames = fuwm_pkg::CNT_OUT_W'(nw);
               s.critical_frames = fuwm_pkg::CNT_OUT_W'(nc);
            end
            stats_expected = {stats_expected, s};
         end
         fuwm_pkg::OP_CLEAR_HISTORY: begin
            ring_head = 0;
            ring_count = 0;
         end
         default: ;
      endcase
   endtask

   // word driver
   always @(posedge clock) begin
      bit hold;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.operation <= fuwm_pkg::OP_BEGIN_FRAME;
         req_if.frame_number <= '0;
         req_if.size_bytes <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            apply_usage_word(word_on_bus);
         end
         if (!req_if.valid || req_if.ready) begin
            hold = !steady && ($urandom_range(0, 99) < 19);
            if (!hold && pending_words.size() != 0) begin
               word_on_bus = pending_words.pop_front();
               req_if.valid <= 1'b1;
               req_if.operation <= word_on_bus.operation;
               req_if.frame_number <= word_on_bus.frame_number;
               req_if.size_bytes <= word_on_bus.size_bytes;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // stats monitor
   always @(posedge clock) begin
      usage_stats_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (stats_expected.size() == 0) begin
               $error("stats word with nothing outstanding");
               mismatches++;
            end else begin
               want = stats_expected.pop_front();
               check_field("average_usage", want.average_usage, rsp_if.average_usage);
               check_field("peak_usage", want.peak_usage, rsp_if.peak_usage);
               check_field("minimum_usage", want.minimum_usage, rsp_if.minimum_usage);
               check_field("frames_counted", 32'(want.frames_counted),
                           32'(rsp_if.frames_counted));
               check_field("warning_frames", 32'(want.warning_frames),
                           32'(rsp_if.warning_frames));
               check_field("critical_frames", 32'(want.critical_frames),
                           32'(rsp_if.critical_frames));
            end
         end
         rsp_if.ready <= steady || ($urandom_range(0, 99) >= 19);
      end
   end

   task automatic add_word(logic [fuwm_pkg::OP_W-1:0] op,
                           logic [fuwm_pkg::FRAME_W-1:0] frame = '0,
                           logic [fuwm_pkg::SIZE_W-1:0] size = '0);
      usage_word_type w;
      w.operation = op;
      w.frame_number = frame;
      w.size_bytes = size;
      pending_words = {pending_words, w};
   endtask

   task automatic write_level(logic [fuwm_pkg::CSR_IDX_W-1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      if (idx == fuwm_pkg::CSR_WARNING_LEVEL) warn_level = value;
      else crit_level = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_levels(logic [31:0] warning, logic [31:0] critical);
      write_level(fuwm_pkg::CSR_WARNING_LEVEL, warning);
      write_level(fuwm_pkg::CSR_CRITICAL_LEVEL, critical);
   endtask

   task automatic drain(int settle);
      while (pending_words.size() != 0 || req_if.valid || stats_expected.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   function automatic logic [fuwm_pkg::SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return fuwm_pkg::SIZE_W'($urandom);
      endcase
   endfunction

   // mostly whole frames with random content, some stray words
   task automatic add_frames(int count, int clear_pct);
      int start;
      int pick;
      logic [31:0] fnum;
      start = pending_words.size();
      while (pending_words.size() - start < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            add_word(fuwm_pkg::OP_W'($urandom_range(0, 3)), $urandom,
                     fuwm_pkg::SIZE_W'($urandom));
         end else if (pick < 8 + clear_pct) begin
            add_word(fuwm_pkg::OP_CLEAR_HISTORY);
         end else if (pick < 28 + clear_pct) begin
            add_word(fuwm_pkg::OP_READ_STATS);
         end else begin
            fnum = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
            add_word(fuwm_pkg::OP_BEGIN_FRAME, fnum);
            repeat ($urandom_range(0, 6)) add_word(fuwm_pkg::OP_ALLOCATE, $urandom, pick_size());
         end
      end
   endtask

   initial begin
      logic [31:0] lvl;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = fuwm_pkg::CSR_WARNING_LEVEL;
      csr_write_data = '0;
      warn_level = '0;
      crit_level = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // levels at reset value
      add_word(fuwm_pkg::OP_READ_STATS);
      add_word(fuwm_pkg::OP_ALLOCATE, '0, '0);
      add_word(fuwm_pkg::OP_ALLOCATE, '0, '1);
      add_word(fuwm_pkg::OP_READ_STATS);
      add_word(fuwm_pkg::OP_BEGIN_FRAME, 32'hFFFF_FFFF);
      add_word(fuwm_pkg::OP_ALLOCATE, '0, 24'd1);
      add_word(fuwm_pkg::OP_READ_STATS);
      add_word(fuwm_pkg::OP_BEGIN_FRAME, 32'd0);
      add_word(fuwm_pkg::OP_ALLOCATE, '0, 24'd5);
      add_word(fuwm_pkg::OP_BEGIN_FRAME, 32'd1);
      add_word(fuwm_pkg::OP_ALLOCATE, '0, '1);
      add_word(fuwm_pkg::OP_ALLOCATE, '0, 24'd3);
      add_word(fuwm_pkg::OP_BEGIN_FRAME, 32'h8000_0000);
      add_word(fuwm_pkg::OP_READ_STATS);
      add_word(fuwm_pkg::OP_CLEAR_HISTORY);
      add_word(fuwm_pkg::OP_READ_STATS);
      add_word(fuwm_pkg::OP_ALLOCATE, '0, 24'h80_0000);
      add_word(fuwm_pkg::OP_BEGIN_FRAME, 32'h5555_AAAA);
      add_word(fuwm_pkg::OP_READ_STATS);
      add_word(fuwm_pkg::OP_CLEAR_HISTORY, 32'hFFFF_FFFF, '1);
      add_word(fuwm_pkg::OP_READ_STATS, 32'hFFFF_FFFF, '1);
      drain(4);

      // saturating frame total
      set_levels(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      add_word(fuwm_pkg::OP_BEGIN_FRAME, 32'h0000_0007);
      repeat (257) add_word(fuwm_pkg::OP_ALLOCATE, '0, '1);
      add_word(fuwm_pkg::OP_READ_STATS);
      add_word(fuwm_pkg::OP_ALLOCATE, '0, 24'd5);
      add_word(fuwm_pkg::OP_BEGIN_FRAME, 32'h0000_0008);
      add_word(fuwm_pkg::OP_READ_STATS);
      drain(4);

      lvl = $urandom_range(0, 40_000_000);
      set_levels(lvl, lvl + $urandom_range(0, 40_000_000));
      add_frames(350, 3);
      drain(4);

      // critical below warning, no idling
      steady = 1'b1;
      lvl = $urandom_range(0, 30_000_000);
      set_levels(lvl + $urandom_range(0, 30_000_000), lvl);
      add_frames(300, 0);
      drain(4);
      steady = 1'b0;

      set_levels(32'd0, 32'hFFFF_FFFF);
      add_frames(350, 0);
      drain(4);

      lvl = $urandom_range(0, 40_000_000);
      set_levels(lvl, lvl);
      add_frames(370, 2);
      drain(120);

      if (mismatches == 0 && stats_expected.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
